// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/itoa_pkg.sv =====
// Shared constants, types and the digit lookup of the integer-to-text converter.
package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int ND_W       = $clog2(VALUE_BITS + 1);

  localparam logic [4:0] RADIX_RESET  = 5'd10;
  localparam logic [4:0] RADIX_MIN    = 5'd2;
  localparam logic [4:0] RADIX_MAX    = 5'd16;
  localparam logic [4:0] RADIX_SIGNED = 5'd10;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ALPHA   = 8'h37;

  typedef struct packed {
    logic       start;
    logic [4:0] radix;
  } itoa_div_ctrl_t;

  typedef struct packed {
    logic       done;
    logic       nonzero;
    logic [3:0] rem;
  } itoa_div_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    return (d < 4'd10) ? (CHAR_ZERO + d8) : (CHAR_ALPHA + d8);
  endfunction

endpackage

// ===== rtl/itoa_divider.sv =====
// Bit-serial restoring divider: divides the value by the radix, one quotient bit per cycle.
module itoa_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  itoa_pkg::itoa_div_ctrl_t            ctrl,
  input  logic [itoa_pkg::VALUE_BITS-1:0]     dividend,
  output itoa_pkg::itoa_div_stat_t            stat,
  output logic [itoa_pkg::VALUE_BITS-1:0]     quotient
);

  logic                          busy;
  logic                          done;
  logic                          nz;
  logic [itoa_pkg::CNT_W-1:0]    cnt;
  logic [3:0]                    rem;
  logic [itoa_pkg::VALUE_BITS-1:0] q;
  logic [4:0]                    trial;
  logic [4:0]                    diff;
  logic                          qbit;

  always_comb begin
    trial = {rem, q[itoa_pkg::VALUE_BITS-1]};
    diff  = trial - ctrl.radix;
    qbit  = (trial >= ctrl.radix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        rem  <= 4'd0;
        nz   <= 1'b0;
      end else if (busy) begin
        q   <= {q[itoa_pkg::VALUE_BITS-2:0], qbit};
        rem <= qbit ? diff[3:0] : trial[3:0];
        nz  <= nz | qbit;
        cnt <= cnt + 1'b1;
        if (cnt == itoa_pkg::CNT_W'(itoa_pkg::VALUE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done    = done;
  assign stat.nonzero = nz;
  assign stat.rem     = rem;
  assign quotient     = q;

endmodule

// ===== rtl/integer_to_ascii_radix_top.sv =====
// Top level of the integer-to-text converter: control, digit stack and output register.
//
//   channel | signals                      | direction
//   --------+------------------------------+----------
//   in      | in_valid, in_ready, value    | in
//   out     | out_valid, out_ready,        | out
//           | character, last              |
//   cfg     | cfg_we, cfg_data (radix)     | in
//
// Each digit comes from the bit-serial divider, after all 32 quotient bits and a hand-off.
// Digits are divided one by one, then sent at one character per cycle when not stalled.
// A new word is taken only when the previous one has been fully loaded into the output.
// Output stalls hold the current character; the divider waits for none.
// Reset sets the radix to ten and empties the digit stack.
`include "assert_macros.svh"

module integer_to_ascii_radix_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [4:0]                            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            character,
  output logic                                  last
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t                          state;
  logic [4:0]                      radix;
  logic [4:0]                      eff_radix;
  logic                            neg;
  logic                            neg_next;
  logic [itoa_pkg::ND_W-1:0]       nd;
  logic [3:0]                      stack [itoa_pkg::VALUE_BITS];
  logic [itoa_pkg::VALUE_BITS-1:0] mag;
  logic [itoa_pkg::VALUE_BITS-1:0] quotient;
  logic [itoa_pkg::VALUE_BITS-1:0] dividend;
  itoa_pkg::itoa_div_ctrl_t        div_ctrl;
  itoa_pkg::itoa_div_stat_t        div_stat;
  logic                            in_acc;
  logic                            out_load;
  logic                            push;
  logic                            pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itoa_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_data;
    end
  end

  always_comb begin
    priority if (radix < itoa_pkg::RADIX_MIN) begin
      eff_radix = itoa_pkg::RADIX_MIN;
    end else if (radix > itoa_pkg::RADIX_MAX) begin
      eff_radix = itoa_pkg::RADIX_MAX;
    end else begin
      eff_radix = radix;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign neg_next = (eff_radix == itoa_pkg::RADIX_SIGNED) && value[itoa_pkg::VALUE_BITS-1];
  assign mag      = neg_next ? (~value + 1'b1) : value;
  assign dividend = (state == S_IDLE) ? mag : quotient;
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);
  assign push     = (state == S_DIV) && div_stat.done;
  assign pop      = out_load && !neg;

  assign div_ctrl.start = in_acc || (push && div_stat.nonzero);
  assign div_ctrl.radix = eff_radix;

  itoa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (dividend),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (push) begin
      stack[0] <= div_stat.rem;
      for (int i = 1; i < itoa_pkg::VALUE_BITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < itoa_pkg::VALUE_BITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      neg       <= 1'b0;
      nd        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            neg   <= neg_next;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (push) begin
            nd <= nd + 1'b1;
            if (!div_stat.nonzero) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (neg) begin
              character <= itoa_pkg::CHAR_MINUS;
              last      <= 1'b0;
              neg       <= 1'b0;
            end else begin
              character <= itoa_pkg::digit_char(stack[0]);
              last      <= (nd == itoa_pkg::ND_W'(1));
              nd        <= nd - 1'b1;
              if (nd == itoa_pkg::ND_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_idle_empty, clk, rst, state == S_IDLE, nd == '0)
  `ASSERT_IMPLIES(a_nd_bound, clk, rst, 1'b1, nd <= itoa_pkg::ND_W'(itoa_pkg::VALUE_BITS))
  `ASSERT_IMPLIES(a_done_in_div, clk, rst, div_stat.done, state == S_DIV)
  `ASSERT_NEXT(a_last_to_idle, clk, rst, out_load && !neg && nd == itoa_pkg::ND_W'(1),
               state == S_IDLE && out_valid && last)

endmodule
